// ===== rtl/gbe_pkg.sv =====
// Shared types and sizing constants for the gap buffer engine.
// No dependencies; imported by gap_buffer_engine.
`timescale 1ns / 1ps

package gbe_pkg;

  // Store geometry.
  localparam int unsigned CAPACITY     = 1024;
  localparam int unsigned ELEMENT_BITS = 8;
  localparam int unsigned ADDR_BITS    = $clog2(CAPACITY);
  localparam int unsigned CNT_BITS     = $clog2(CAPACITY + 1);

  // Beat field widths.
  localparam int unsigned OP_BITS       = 3;
  localparam int unsigned IDX_BITS      = 11;
  localparam int unsigned IN_DATA_BITS  = 48;
  localparam int unsigned OUT_DATA_BITS = 32;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT        = 3'd0,
    OP_READ          = 3'd1,
    OP_SEEK          = 3'd2,
    OP_REMOVE_BEFORE = 3'd3,
    OP_REMOVE_AFTER  = 3'd4,
    OP_REMOVE_RANGE  = 3'd5,
    OP_WRITE         = 3'd6,
    OP_CLEAR         = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_FINISH
  } state_e;

  typedef logic [CNT_BITS-1:0]     cnt_t;
  typedef logic [ADDR_BITS-1:0]    addr_t;
  typedef logic [ELEMENT_BITS-1:0] elem_t;

endpackage

// ===== rtl/gap_buffer_engine.sv =====
// Gap buffer engine: element store, count and insertion point, one result per operation.
// Depends on gbe_pkg for sizing constants, the opcode and state enums.
`timescale 1ns / 1ps

// Channel   Dir  Beat contents (lowest bits first)
// s_axis    in   opcode[2:0], position[13:3], range_end[24:14], amount[35:25],
//                element_in[43:36], zero fill to 48 bits
// m_axis    out  status[0], element_out[8:1], element_count[19:9], cursor[30:20],
//                zero fill to 32 bits
//
// Insert, read, write, the two plain removes and clear do the checks and the store
// access in the accept cycle; the finish state then loads the output register. A rejected
// beat, a seek that lands on the current point and a remove range that needs no move
// take the same path. A seek or a remove range that has to move the point first passes
// through the move state, which carries the elements across the gap one element per
// cycle through the single store read port, each element written in the cycle after
// its read.
// Reset clears the count and the point; store contents stay undefined until written.
// A new beat is taken only while idle; a stalled output beat holds the engine in its
// final cycle until the downstream side takes the previous result.

module gap_buffer_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // opcode, position, range_end, amount, element_in, zero fill
  input  logic [gbe_pkg::IN_DATA_BITS-1:0]    s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // status, element_out, element_count, cursor, zero fill
  output logic [gbe_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata_o
);

  import gbe_pkg::*;

  localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);

  // Input beat fields.
  op_e                 in_op;
  logic [IDX_BITS-1:0] in_pos;
  logic [IDX_BITS-1:0] in_end;
  logic [IDX_BITS-1:0] in_amt;
  elem_t               in_elem;

  assign in_op   = op_e'(s_axis_tdata_i[2:0]);
  assign in_pos  = s_axis_tdata_i[13:3];
  assign in_end  = s_axis_tdata_i[24:14];
  assign in_amt  = s_axis_tdata_i[35:25];
  assign in_elem = s_axis_tdata_i[43:36];

  // Control state.
  state_e state_q, state_d;
  cnt_t   count_q, count_d;
  cnt_t   gap_q, gap_d;
  logic   pend_q, pend_d;
  logic   out_valid_q, out_valid_d;

  // Per-operation payload.
  cnt_t   mv_k_q, mv_k_d;
  cnt_t   mv_tgt_q, mv_tgt_d;
  addr_t  pend_addr_q, pend_addr_d;
  logic   rm_pending_q, rm_pending_d;
  cnt_t   rm_pos_q, rm_pos_d;
  cnt_t   rm_end_q, rm_end_d;
  logic   rd_use_q, rd_use_d;
  logic   status_q, status_d;

  // Output register.
  logic   out_status_q, out_status_d;
  elem_t  out_elem_q, out_elem_d;
  cnt_t   out_count_q, out_count_d;
  cnt_t   out_cursor_q, out_cursor_d;

  // Store ports.
  elem_t  element_store_q [CAPACITY];
  elem_t  rdata_q;
  logic   mem_we, mem_re;
  addr_t  mem_waddr, mem_raddr;
  elem_t  mem_wdata;

  // Derived values from the current count and point.
  cnt_t   gap_len;
  cnt_t   pos_c, end_c, amt_c;
  cnt_t   phys_pos;
  cnt_t   seek_tgt;
  logic [CNT_BITS:0] gap_plus_amt;
  logic   out_free;

  assign gap_len      = CAP_CNT - count_q;
  assign pos_c        = cnt_t'(in_pos);
  assign end_c        = cnt_t'(in_end);
  assign amt_c        = cnt_t'(in_amt);
  assign phys_pos     = (pos_c >= gap_q) ? (pos_c + gap_len) : pos_c;
  assign seek_tgt     = (pos_c > count_q) ? count_q : pos_c;
  assign gap_plus_amt = {1'b0, gap_q} + {1'b0, amt_c};
  assign out_free     = !out_valid_q || m_axis_tready_i;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_cursor_q, out_count_q, out_elem_q, out_status_q};

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    gap_d        = gap_q;
    pend_d       = 1'b0;
    pend_addr_d  = pend_addr_q;
    mv_k_d       = mv_k_q;
    mv_tgt_d     = mv_tgt_q;
    rm_pending_d = rm_pending_q;
    rm_pos_d     = rm_pos_q;
    rm_end_d     = rm_end_q;
    rd_use_d     = rd_use_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_elem_d   = out_elem_q;
    out_count_d  = out_count_q;
    out_cursor_d = out_cursor_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = gap_q[ADDR_BITS-1:0];
    mem_raddr    = phys_pos[ADDR_BITS-1:0];
    mem_wdata    = in_elem;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d      = ST_FINISH;
          status_d     = 1'b0;
          rd_use_d     = 1'b0;
          rm_pending_d = 1'b0;
          rm_pos_d     = pos_c;
          rm_end_d     = end_c;
          unique case (in_op)
            OP_INSERT: begin
              if (count_q >= CAP_CNT) begin
                status_d = 1'b1;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + cnt_t'(1);
                gap_d   = gap_q + cnt_t'(1);
              end
            end
            OP_READ: begin
              if (pos_c >= count_q) begin
                status_d = 1'b1;
              end else begin
                mem_re   = 1'b1;
                rd_use_d = 1'b1;
              end
            end
            OP_SEEK: begin
              // The clamped target never rejects; equal target means no moves.
              if (seek_tgt != gap_q) begin
                mv_k_d   = gap_q;
                mv_tgt_d = seek_tgt;
                state_d  = ST_MOVE;
              end
            end
            OP_REMOVE_BEFORE: begin
              if (amt_c > gap_q) begin
                status_d = 1'b1;
              end else begin
                count_d = count_q - amt_c;
                gap_d   = gap_q - amt_c;
              end
            end
            OP_REMOVE_AFTER: begin
              if ({1'b0, count_q} < gap_plus_amt) begin
                status_d = 1'b1;
              end else begin
                count_d = count_q - amt_c;
              end
            end
            OP_REMOVE_RANGE: begin
              if (end_c <= pos_c || end_c > count_q) begin
                status_d = 1'b1;
              end else if (pos_c > gap_q) begin
                // The whole range lies past the point: bring the point to its start.
                mv_k_d       = gap_q;
                mv_tgt_d     = pos_c;
                rm_pending_d = 1'b1;
                state_d      = ST_MOVE;
              end else if (end_c < gap_q) begin
                // The whole range lies before the point: bring the point to its end.
                mv_k_d       = gap_q;
                mv_tgt_d     = end_c;
                rm_pending_d = 1'b1;
                state_d      = ST_MOVE;
              end else begin
                count_d = count_q - (end_c - pos_c);
                gap_d   = pos_c;
              end
            end
            OP_WRITE: begin
              if (pos_c >= count_q) begin
                status_d = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = phys_pos[ADDR_BITS-1:0];
              end
            end
            OP_CLEAR: begin
              count_d = '0;
              gap_d   = '0;
            end
          endcase
        end
      end

      ST_MOVE: begin
        // Each cycle reads the next element to carry across the gap and writes
        // the one read in the cycle before.
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_q;
          mem_wdata = rdata_q;
        end
        if (mv_k_q != mv_tgt_q) begin
          mem_re = 1'b1;
          pend_d = 1'b1;
          if (mv_tgt_q > mv_k_q) begin
            mem_raddr   = ADDR_BITS'(mv_k_q + gap_len);
            pend_addr_d = mv_k_q[ADDR_BITS-1:0];
            mv_k_d      = mv_k_q + cnt_t'(1);
          end else begin
            mem_raddr   = ADDR_BITS'(mv_k_q - cnt_t'(1));
            pend_addr_d = ADDR_BITS'(mv_k_q - cnt_t'(1) + gap_len);
            mv_k_d      = mv_k_q - cnt_t'(1);
          end
        end else begin
          state_d = ST_FINISH;
          if (rm_pending_q) begin
            count_d = count_q - (rm_end_q - rm_pos_q);
            gap_d   = rm_pos_q;
          end else begin
            gap_d = mv_tgt_q;
          end
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_elem_d   = rd_use_q ? rdata_q : '0;
          out_count_d  = count_q;
          out_cursor_d = gap_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      gap_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      gap_q       <= gap_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mv_k_q       <= mv_k_d;
    mv_tgt_q     <= mv_tgt_d;
    pend_addr_q  <= pend_addr_d;
    rm_pending_q <= rm_pending_d;
    rm_pos_q     <= rm_pos_d;
    rm_end_q     <= rm_end_d;
    rd_use_q     <= rd_use_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_elem_q   <= out_elem_d;
    out_count_q  <= out_count_d;
    out_cursor_q <= out_cursor_d;
  end

  // Element store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      element_store_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= element_store_q[mem_raddr];
    end
  end

endmodule
